// ----- hdl/ccs_pkg.sv -----
package ccs_pkg;

  localparam int unsigned LineW = 24;

  localparam logic [7:0] ChSlash   = 8'h2f;
  localparam logic [7:0] ChStar    = 8'h2a;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChNewline = 8'h0a;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChCr      = 8'h0d;

  localparam logic [1:0] ErrNone     = 2'd0;
  localparam logic [1:0] ErrString   = 2'd1;
  localparam logic [1:0] ErrComment  = 2'd2;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = QPtrW + 1;

  typedef struct packed {
    logic [7:0]       out_char;
    logic             char_valid;
    logic             line_end;
    logic             line_blank;
    logic [LineW-1:0] line_num;
    logic [1:0]       error_code;
    logic             last;
  } res_t;

  function automatic res_t make_res(logic [7:0] c, logic valid, logic le, logic blank,
                                    logic [LineW-1:0] lineno, logic [1:0] err);
    res_t r;
    r.out_char    = c;
    r.char_valid  = valid;
    r.line_end    = le;
    r.line_blank  = blank;
    r.line_num    = lineno;
    r.error_code  = err;
    r.last        = 1'b0;
    return r;
  endfunction

  function automatic logic is_ws(logic [7:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

endpackage

// ----- hdl/ccs_fifo.sv -----
module ccs_fifo import ccs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_cnt_i,
  input  res_t       wdata0_i,
  input  res_t       wdata1_i,
  output logic       room2_o,
  output logic       valid_o,
  input  logic       pop_i,
  output res_t       rdata_o
);

  res_t             mem_q [QDepth];
  logic [QPtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_pop;

  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rp_q];
  assign room2_o = (cnt_q <= QCntW'(QDepth - 2));
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wp_d  = wp_q + QPtrW'(push_cnt_i);
    rp_d  = rp_q + QPtrW'(do_pop);
    cnt_d = cnt_q + QCntW'(push_cnt_i) - QCntW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wp_q] <= wdata0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wp_q + QPtrW'(1)] <= wdata1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- hdl/c_comment_stripper.sv -----
// Byte-serial C comment stripper. One text byte (or an end-of-stream mark) is
// taken per beat and the scan state is updated in the same cycle; its results,
// at most two per byte, go into a four-entry result queue that drives the
// output channel one result per cycle while the output is ready. A byte is taken
// whenever the queue has room for two results, so a steady stream runs at one byte
// per cycle while the output keeps up; a '/' that turns out not to open a comment
// gives two results for the next byte. Line numbers start at 1 and wrap at 2^24;
// end of stream returns every scan state element to its reset value.
module c_comment_stripper import ccs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       ch_i,
  input  logic             end_of_stream_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_char_o,
  output logic             char_valid_o,
  output logic             line_end_o,
  output logic             line_blank_o,
  output logic [LineW-1:0] line_num_o,
  output logic [1:0]       error_code_o,
  output logic             last_o
);

  typedef enum logic [2:0] {
    MNormal = 3'd0,
    MSlash  = 3'd1,
    MLine   = 3'd2,
    MBlock  = 3'd3,
    MBStar  = 3'd4,
    MString = 3'd5
  } mode_e;

  mode_e            mode_q, mode_d;
  logic             opened_q, opened_d;
  logic             text_q, text_d;
  logic [LineW-1:0] line_q, line_d;
  logic [LineW-1:0] cstart_q, cstart_d;
  res_t             res_d [2];
  logic [1:0]       cnt_d;
  logic [1:0]       push_cnt;
  logic             accept;
  logic             room2;
  res_t             head;

  assign in_ready_o = room2;
  assign accept     = in_valid_i && room2;
  assign push_cnt   = accept ? cnt_d : 2'd0;

  always_comb begin
    mode_e m;
    logic  done;
    mode_d   = mode_q;
    opened_d = opened_q;
    text_d   = text_q;
    line_d   = line_q;
    cstart_d = cstart_q;
    res_d[0] = '0;
    res_d[1] = '0;
    cnt_d    = 2'd0;
    m        = mode_q;
    done     = 1'b0;
    if (end_of_stream_i) begin
      unique case (mode_q)
        MSlash: begin
          res_d[0] = make_res(ChSlash, 1'b1, 1'b0, 1'b0, line_q, ErrNone);
          cnt_d    = 2'd1;
        end
        MBlock, MBStar: begin
          res_d[0] = make_res(8'd0, 1'b0, 1'b0, 1'b0, cstart_q, ErrComment);
          cnt_d    = 2'd1;
        end
        MString: begin
          res_d[0] = make_res(8'd0, 1'b0, 1'b0, 1'b0, line_q, ErrString);
          cnt_d    = 2'd1;
        end
        default: ;
      endcase
      mode_d   = MNormal;
      opened_d = 1'b0;
      text_d   = 1'b0;
      line_d   = LineW'(1);
      cstart_d = '0;
    end else begin
      if (mode_q == MSlash) begin
        if (ch_i == ChSlash) begin
          mode_d = MLine;
          done   = 1'b1;
        end else if (ch_i == ChStar) begin
          mode_d   = MBlock;
          opened_d = 1'b1;
          cstart_d = line_q;
          done     = 1'b1;
        end else begin
          res_d[0] = make_res(ChSlash, 1'b1, 1'b0, 1'b0, line_q, ErrNone);
          cnt_d    = 2'd1;
          text_d   = 1'b1;
          m        = MNormal;
          mode_d   = MNormal;
        end
      end
      if (!done) begin
        unique case (m)
          MString: begin
            if (ch_i == ChNewline) begin
              res_d[cnt_d[0]] = make_res(8'd0, 1'b0, 1'b1, !text_d, line_d, ErrString);
              cnt_d    = cnt_d + 2'd1;
              text_d   = 1'b0;
              opened_d = 1'b0;
              line_d   = line_d + LineW'(1);
              mode_d   = MNormal;
            end else begin
              res_d[cnt_d[0]] = make_res(ch_i, 1'b1, 1'b0, 1'b0, line_d, ErrNone);
              cnt_d = cnt_d + 2'd1;
              if (!is_ws(ch_i)) begin
                text_d = 1'b1;
              end
              if (ch_i == ChQuote) begin
                mode_d = MNormal;
              end
            end
          end
          MLine: begin
            if (ch_i == ChNewline) begin
              res_d[cnt_d[0]] = make_res(8'd0, 1'b0, 1'b1, !text_d, line_d, ErrNone);
              cnt_d    = cnt_d + 2'd1;
              text_d   = 1'b0;
              opened_d = 1'b0;
              line_d   = line_d + LineW'(1);
              mode_d   = MNormal;
            end
          end
          MBlock: begin
            if (ch_i == ChNewline) begin
              res_d[cnt_d[0]] = make_res(8'd0, 1'b0, 1'b1, !text_d, line_d, ErrNone);
              cnt_d    = cnt_d + 2'd1;
              text_d   = 1'b0;
              opened_d = 1'b0;
              line_d   = line_d + LineW'(1);
            end else if (ch_i == ChStar) begin
              mode_d = MBStar;
            end
          end
          MBStar: begin
            if (ch_i == ChSlash) begin
              if (opened_d) begin
                res_d[cnt_d[0]] = make_res(ChSpace, 1'b1, 1'b0, 1'b0, line_d, ErrNone);
                cnt_d = cnt_d + 2'd1;
              end
              opened_d = 1'b0;
              mode_d   = MNormal;
            end else if (ch_i == ChNewline) begin
              res_d[cnt_d[0]] = make_res(8'd0, 1'b0, 1'b1, !text_d, line_d, ErrNone);
              cnt_d    = cnt_d + 2'd1;
              text_d   = 1'b0;
              opened_d = 1'b0;
              line_d   = line_d + LineW'(1);
              mode_d   = MBlock;
            end else if (ch_i != ChStar) begin
              mode_d = MBlock;
            end
          end
          default: begin
            mode_d = MNormal;
            if (ch_i == ChNewline) begin
              res_d[cnt_d[0]] = make_res(8'd0, 1'b0, 1'b1, !text_d, line_d, ErrNone);
              cnt_d    = cnt_d + 2'd1;
              text_d   = 1'b0;
              opened_d = 1'b0;
              line_d   = line_d + LineW'(1);
            end else if (ch_i == ChSlash) begin
              mode_d = MSlash;
            end else begin
              res_d[cnt_d[0]] = make_res(ch_i, 1'b1, 1'b0, 1'b0, line_d, ErrNone);
              cnt_d = cnt_d + 2'd1;
              if (!is_ws(ch_i)) begin
                text_d = 1'b1;
              end
              if (ch_i == ChQuote) begin
                mode_d = MString;
              end
            end
          end
        endcase
      end
    end
    if (cnt_d == 2'd2) begin
      res_d[1].last = 1'b1;
    end else if (cnt_d == 2'd1) begin
      res_d[0].last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MNormal;
      opened_q <= 1'b0;
      text_q   <= 1'b0;
      line_q   <= LineW'(1);
      cstart_q <= '0;
    end else if (accept) begin
      mode_q   <= mode_d;
      opened_q <= opened_d;
      text_q   <= text_d;
      line_q   <= line_d;
      cstart_q <= cstart_d;
    end
  end

  ccs_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .wdata0_i   (res_d[0]),
    .wdata1_i   (res_d[1]),
    .room2_o    (room2),
    .valid_o    (out_valid_o),
    .pop_i      (out_ready_i),
    .rdata_o    (head)
  );

  assign out_char_o    = head.out_char;
  assign char_valid_o  = head.char_valid;
  assign line_end_o    = head.line_end;
  assign line_blank_o  = head.line_blank;
  assign line_num_o    = head.line_num;
  assign error_code_o  = head.error_code;
  assign last_o        = head.last;

endmodule

// ----- tb/ccs_stripper_checker.sv -----
`timescale 1ns / 100ps

module ccs_stripper_checker import ccs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [7:0]       ch_i,
  input  logic             end_of_stream_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [7:0]       out_char_i,
  input  logic             char_valid_i,
  input  logic             line_end_i,
  input  logic             line_blank_i,
  input  logic [LineW-1:0] line_num_i,
  input  logic [1:0]       error_code_i,
  input  logic             last_i,
  output int               fail_count_o,
  output int               pending_o
);

  typedef enum logic [2:0] {
    ScanText,
    ScanSlash,
    ScanLine,
    ScanBlock,
    ScanBlockStar,
    ScanString
  } scan_mode_e;

  scan_mode_e       scan_mode   = ScanText;
  logic             opened_here = 1'b0;
  logic             has_text    = 1'b0;
  logic [LineW-1:0] line_no     = LineW'(1);
  logic [LineW-1:0] open_line   = '0;
  res_t             stripped_q[$];
  int               mismatches  = 0;

  function automatic logic blank_byte(logic [7:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  function automatic void reset_scan();
    scan_mode   = ScanText;
    opened_here = 1'b0;
    has_text    = 1'b0;
    line_no     = LineW'(1);
    open_line   = '0;
  endfunction

  function automatic void push_result(logic [7:0] c, logic cv, logic le, logic blank,
                                      logic [LineW-1:0] ln, logic [1:0] err);
    res_t r;
    r = '{out_char: c, char_valid: cv, line_end: le, line_blank: blank,
          line_num: ln, error_code: err, last: 1'b0};
    stripped_q.push_back(r);
  endfunction

  function automatic void keep_byte(logic [7:0] c);
    push_result(c, 1'b1, 1'b0, 1'b0, line_no, ErrNone);
    if (!blank_byte(c)) has_text = 1'b1;
  endfunction

  function automatic void close_line(logic [1:0] err);
    push_result(8'h00, 1'b0, 1'b1, !has_text, line_no, err);
    has_text    = 1'b0;
    opened_here = 1'b0;
    line_no     = line_no + 1'b1;
  endfunction

  function automatic void scan_byte(logic [7:0] c, logic eos);
    int   first;
    logic taken;
    res_t tail;
    first = stripped_q.size();
    taken = 1'b0;
    if (eos) begin
      case (scan_mode)
        ScanSlash: push_result(ChSlash, 1'b1, 1'b0, 1'b0, line_no, ErrNone);
        ScanBlock, ScanBlockStar: push_result(8'h00, 1'b0, 1'b0, 1'b0, open_line, ErrComment);
        ScanString: push_result(8'h00, 1'b0, 1'b0, 1'b0, line_no, ErrString);
        default: ;
      endcase
      reset_scan();
      taken = 1'b1;
    end else if (scan_mode == ScanSlash) begin
      if (c == ChSlash) begin
        scan_mode = ScanLine;
        taken     = 1'b1;
      end else if (c == ChStar) begin
        scan_mode   = ScanBlock;
        opened_here = 1'b1;
        open_line   = line_no;
        taken       = 1'b1;
      end else begin
        keep_byte(ChSlash);
        scan_mode = ScanText;
      end
    end
    if (!taken) begin
      case (scan_mode)
        ScanString: begin
          if (c == ChNewline) begin
            close_line(ErrString);
            scan_mode = ScanText;
          end else begin
            keep_byte(c);
            if (c == ChQuote) scan_mode = ScanText;
          end
        end
        ScanLine: begin
          if (c == ChNewline) begin
            close_line(ErrNone);
            scan_mode = ScanText;
          end
        end
        ScanBlock: begin
          if (c == ChNewline) close_line(ErrNone);
          else if (c == ChStar) scan_mode = ScanBlockStar;
        end
        ScanBlockStar: begin
          if (c == ChSlash) begin
            if (opened_here) keep_byte(ChSpace);
            opened_here = 1'b0;
            scan_mode   = ScanText;
          end else if (c == ChNewline) begin
            close_line(ErrNone);
            scan_mode = ScanBlock;
          end else if (c != ChStar) begin
            scan_mode = ScanBlock;
          end
        end
        default: begin
          scan_mode = ScanText;
          if (c == ChNewline) begin
            close_line(ErrNone);
          end else if (c == ChSlash) begin
            scan_mode = ScanSlash;
          end else begin
            keep_byte(c);
            if (c == ChQuote) scan_mode = ScanString;
          end
        end
      endcase
    end
    if (stripped_q.size() > first) begin
      tail      = stripped_q.pop_back();
      tail.last = 1'b1;
      stripped_q.push_back(tail);
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      reset_scan();
      stripped_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) scan_byte(ch_i, end_of_stream_i);
      if (out_valid_i && out_ready_i) begin
        if (stripped_q.size() == 0) begin
          $error("result beat with nothing expected: out_char %0d line_num %0d",
                 out_char_i, line_num_i);
          mismatches++;
        end else begin
          want = stripped_q.pop_front();
          check_field("out_char", 32'(want.out_char), 32'(out_char_i));
          check_field("char_valid", 32'(want.char_valid), 32'(char_valid_i));
          check_field("line_end", 32'(want.line_end), 32'(line_end_i));
          check_field("line_blank", 32'(want.line_blank), 32'(line_blank_i));
          check_field("line_num", 32'(want.line_num), 32'(line_num_i));
          check_field("error_code", 32'(want.error_code), 32'(error_code_i));
          check_field("last", 32'(want.last), 32'(last_i));
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= stripped_q.size();
  end

endmodule

// ----- tb/tb_c_comment_stripper.sv -----
`timescale 1ns / 100ps

module tb_c_comment_stripper import ccs_pkg::*; ();

  localparam int NumBeats   = 650;
  localparam int StallLimit = 2000;
  localparam logic [8:0] EosBeat = 9'h100;

  logic             clk           = 1'b0;
  logic             rst_n         = 1'b0;
  logic             in_valid      = 1'b0;
  logic [7:0]       ch            = 8'h00;
  logic             end_of_stream = 1'b0;
  logic             out_ready     = 1'b0;
  logic             in_ready;
  logic             out_valid;
  logic [7:0]       out_char;
  logic             char_valid;
  logic             line_end;
  logic             line_blank;
  logic [LineW-1:0] line_num;
  logic [1:0]       error_code;
  logic             res_last;
  int               fail_count;
  int               pending;
  int               beats_sent    = 0;
  bit               calm          = 1'b0;

  logic [8:0] directed_beats[$] = '{
    9'h0ff, {1'b0, ChSlash}, 9'h000,
    {1'b0, ChSlash}, {1'b0, ChStar}, {1'b0, ChStar}, {1'b0, ChSlash},
    {1'b0, ChQuote}, {1'b0, ChSlash}, {1'b0, ChSlash}, {1'b0, ChNewline},
    {1'b0, ChSlash}, {1'b0, ChSlash}, {1'b0, ChNewline},
    {1'b0, ChSlash}, {1'b0, ChStar}, {1'b0, ChNewline}, {1'b0, ChStar}, {1'b0, ChSlash},
    {1'b0, ChSlash}, EosBeat,
    {1'b0, ChSlash}, {1'b0, ChStar}, EosBeat,
    {1'b0, ChQuote}, EosBeat,
    EosBeat
  };

  always #5 clk = ~clk;

  c_comment_stripper DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .ch_i           (ch),
    .end_of_stream_i(end_of_stream),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .out_char_o     (out_char),
    .char_valid_o   (char_valid),
    .line_end_o     (line_end),
    .line_blank_o   (line_blank),
    .line_num_o     (line_num),
    .error_code_o   (error_code),
    .last_o         (res_last)
  );

  ccs_stripper_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .ch_i           (ch),
    .end_of_stream_i(end_of_stream),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_char_i     (out_char),
    .char_valid_i   (char_valid),
    .line_end_i     (line_end),
    .line_blank_i   (line_blank),
    .line_num_i     (line_num),
    .error_code_i   (error_code),
    .last_i         (res_last),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  function automatic logic [7:0] text_byte();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return ChSlash;
    else if (roll < 20) return ChStar;
    else if (roll < 28) return ChQuote;
    else if (roll < 40) return ChNewline;
    else if (roll < 48) return ChSpace;
    else if (roll < 52) return ChTab;
    else if (roll < 90) return 8'($urandom_range(0, 25) + 97);
    else return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_beat(input logic [7:0] c, input logic eos);
    int gap;
    if (beats_sent % 64 == 0) calm = ($urandom_range(0, 2) == 0);
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    ch            <= c;
    end_of_stream <= eos;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int stall;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int roll;
    int body;
    bit paused;
    paused = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_beats[i]) send_beat(directed_beats[i][7:0], directed_beats[i][8]);

    while (beats_sent < NumBeats) begin
      roll = $urandom_range(0, 9);
      body = $urandom_range(0, 6);
      if (roll < 3) begin
        send_beat(ChSlash, 1'b0);
        send_beat(ChStar, 1'b0);
        repeat (body) send_beat(text_byte(), 1'b0);
        if ($urandom_range(0, 7) != 0) begin
          send_beat(ChStar, 1'b0);
          send_beat(ChSlash, 1'b0);
        end
      end else if (roll < 5) begin
        send_beat(ChSlash, 1'b0);
        send_beat(ChSlash, 1'b0);
        repeat (body) send_beat(text_byte(), 1'b0);
        send_beat(ChNewline, 1'b0);
      end else if (roll < 7) begin
        send_beat(ChQuote, 1'b0);
        repeat (body) send_beat(text_byte(), 1'b0);
        send_beat(ChQuote, 1'b0);
      end else if (roll == 7 && $urandom_range(0, 2) == 0) begin
        send_beat(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        repeat (body + 1) send_beat(text_byte(), 1'b0);
      end
      if (!paused && beats_sent >= NumBeats / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
    end

    hold_until_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/ccs_pkg.sv
hdl/ccs_fifo.sv
hdl/c_comment_stripper.sv
tb/ccs_stripper_checker.sv
tb/tb_c_comment_stripper.sv
